[sv/assert_macros.svh]
// Assertion macros shared by the sorted priority queue RTL.
// Included by files that carry concurrent checks; needs no other file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked check that is switched off while reset is asserted.
`define SPQ_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
// Clocked check that also holds during reset.
`define SPQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SPQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define SPQ_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

[sv/spq_pkg.sv]
// Package for the sorted priority queue: sizes, codes and item types.
// Used by the interfaces, the cell and the top level; depends on nothing.
package spq_pkg;

	localparam int QUEUE_DEPTH = 64;
	localparam int PRIO_W      = 16;
	localparam int HANDLE_W    = 16;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic {
		ACT_INSERT = 1'b0,
		ACT_REMOVE = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// One stored entry of the queue.
	typedef struct packed {
		logic [PRIO_W-1:0]   prio;
		logic [HANDLE_W-1:0] handle;
	} entry_t;

	// Shift commands broadcast to every cell.
	typedef struct packed {
		logic ins;
		logic deq;
	} ctl_t;

	typedef struct packed {
		action_t             action;
		logic [PRIO_W-1:0]   item_priority;
		logic [HANDLE_W-1:0] item_handle;
	} req_t;

	typedef struct packed {
		logic                out_valid;
		logic [HANDLE_W-1:0] out_handle;
		logic [PRIO_W-1:0]   out_priority;
		logic                queue_empty;
		logic [CNT_W-1:0]    fill_count;
		status_t             status;
	} rsp_t;

endpackage

[sv/spq_if.sv]
// Valid/ready channel interfaces for the request and result items.
// Depends on spq_pkg for the payload types.
interface spq_req_if;
	logic          valid;
	logic          ready;
	spq_pkg::req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface spq_rsp_if;
	logic          valid;
	logic          ready;
	spq_pkg::rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[sv/spq_cell.sv]
// One slot of the sorted queue: holds an entry and shifts with its neighbors.
// Depends on spq_pkg for the entry and command types.
module spq_cell (
	input  logic            clk,
	input  spq_pkg::ctl_t   ctl,
	input  logic            is_head,
	input  logic            occupied,
	input  logic            left_stay,
	input  spq_pkg::entry_t new_entry,
	input  spq_pkg::entry_t left_entry,
	input  spq_pkg::entry_t right_entry,
	output logic            stay,
	output spq_pkg::entry_t entry
);

	spq_pkg::entry_t entry_q;

	// The entry keeps its slot when it is served before the new one.
	// A tie with the head keeps the head; a tie further down yields.
	always_comb begin
		if (is_head) begin
			stay = occupied && !(new_entry.prio < entry_q.prio);
		end else begin
			stay = occupied && (entry_q.prio < new_entry.prio);
		end
	end

	// Insert: keep, take the new entry at the boundary, or shift right.
	// Dequeue: every cell takes its right neighbor's entry.
	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (!stay) begin
				entry_q <= left_stay ? new_entry : left_entry;
			end
		end else if (ctl.deq) begin
			entry_q <= right_entry;
		end
	end

	assign entry = entry_q;

endmodule

[sv/sorted_priority_queue_top.sv]
// Top level of the sorted priority queue: a row of compare-and-shift cells,
// the fill count and the result register. Depends on spq_pkg, spq_if, spq_cell.
//
//  channel | dir | payload                                          | handshake
//  req     | in  | action, item_priority, item_handle               | valid/ready
//  rsp     | out | out_valid, out_handle, out_priority, queue_empty, | valid/ready
//          |     | fill_count, status                               |
//
// Each item is handled at its accepting edge: all cells compare against the new priority in
// parallel and shift at that edge, and its result is offered on rsp in the next cycle.
// A new item is taken each cycle while the result register is free or being read.
// A stall on rsp holds the result and stops req until the result is taken.
// After reset the queue is empty; stored entries need no clearing.
`include "assert_macros.svh"

module sorted_priority_queue_top (
	input  logic      clk,
	input  logic      arst_n,
	spq_req_if.sink   req,
	spq_rsp_if.source rsp
);

	logic [spq_pkg::CNT_W-1:0] count_q;
	logic                      rsp_valid_q;
	spq_pkg::rsp_t             rsp_q;
	spq_pkg::rsp_t             rsp_d;
	spq_pkg::ctl_t             ctl;
	spq_pkg::entry_t           new_entry;
	spq_pkg::entry_t           cell_entry [spq_pkg::QUEUE_DEPTH];
	logic                      cell_stay [spq_pkg::QUEUE_DEPTH];
	logic                      accept;
	logic                      full;
	logic                      empty;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign full      = (count_q == spq_pkg::CNT_W'(spq_pkg::QUEUE_DEPTH));
	assign empty     = (count_q == '0);

	assign new_entry.prio   = req.data.item_priority;
	assign new_entry.handle = req.data.item_handle;

	// Shift commands: a dropped insert or an empty dequeue leaves the cells alone.
	assign ctl.ins = accept && (req.data.action == spq_pkg::ACT_INSERT) && !full;
	assign ctl.deq = accept && (req.data.action == spq_pkg::ACT_REMOVE) && !empty;

	// Row of cells; each sees its left and right neighbor.
	for (genvar i = 0; i < spq_pkg::QUEUE_DEPTH; i++) begin : g_cell
		spq_pkg::entry_t left_entry;
		spq_pkg::entry_t right_entry;
		logic            left_stay;

		if (i == 0) begin : g_first
			assign left_entry = '0;
			assign left_stay  = 1'b1;
		end else begin : g_inner
			assign left_entry = cell_entry[i-1];
			assign left_stay  = cell_stay[i-1];
		end

		if (i == spq_pkg::QUEUE_DEPTH - 1) begin : g_last
			assign right_entry = '0;
		end else begin : g_body
			assign right_entry = cell_entry[i+1];
		end

		spq_cell u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.is_head     (i == 0),
			.occupied    (count_q > spq_pkg::CNT_W'(i)),
			.left_stay   (left_stay),
			.new_entry   (new_entry),
			.left_entry  (left_entry),
			.right_entry (right_entry),
			.stay        (cell_stay[i]),
			.entry       (cell_entry[i])
		);
	end

	// Result of the item being accepted, with the count after it.
	always_comb begin
		rsp_d              = '0;
		rsp_d.status       = spq_pkg::ST_OK;
		rsp_d.fill_count   = count_q;
		if (req.data.action == spq_pkg::ACT_INSERT) begin
			if (full) begin
				rsp_d.status = spq_pkg::ST_FULL;
			end else begin
				rsp_d.fill_count = count_q + 1'b1;
			end
		end else begin
			if (empty) begin
				rsp_d.status = spq_pkg::ST_EMPTY;
			end else begin
				rsp_d.out_valid    = 1'b1;
				rsp_d.out_handle   = cell_entry[0].handle;
				rsp_d.out_priority = cell_entry[0].prio;
				rsp_d.fill_count   = count_q - 1'b1;
			end
		end
		rsp_d.queue_empty = (rsp_d.fill_count == '0);
	end

	// Fill count and result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= rsp_d.fill_count;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	// Checks on the queue state.
	`SPQ_ASSERT(a_count_bound, clk, arst_n, count_q <= spq_pkg::CNT_W'(spq_pkg::QUEUE_DEPTH), "fill count above depth")
	`SPQ_ASSERT(a_full_drop, clk, arst_n, (ctl.ins == 1'b0 && accept && req.data.action == spq_pkg::ACT_INSERT) |=> (rsp.data.status == spq_pkg::ST_FULL && $stable(count_q)), "full insert changed the queue")
	`SPQ_ASSERT(a_deq_count, clk, arst_n, ctl.deq |=> (rsp.data.out_valid && count_q == $past(count_q) - 1'b1), "dequeue did not pop one entry")
	`SPQ_ASSERT(a_head_order, clk, arst_n, (count_q >= spq_pkg::CNT_W'(2)) |-> (cell_entry[0].prio <= cell_entry[1].prio), "head out of order")

endmodule

[bench/testbench.sv]
// Self-checking bench for sorted_priority_queue_top: directed and random inserts and
// dequeues on the request channel, each result checked against the directed table or an in-bench queue model.
// Depends on spq_pkg, spq_if and the RTL of the top level.
module testbench;
	import spq_pkg::*;

	localparam int RANDOM_ITEMS = 1064;
	localparam int QUIET_TAIL   = 150;
	localparam int SEGMENT      = 32;
	localparam int STALL_LIMIT  = 200;
	localparam int NUM_ROWS     = 16;

	// One row of the directed table: a repeat count above one sends random content.
	typedef struct {
		action_t         act;
		logic [PRIO_W-1:0]   prio;
		logic [HANDLE_W-1:0] handle;
		int              reps;
		bit              typed;
		rsp_t            exp;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;

	spq_req_if req ();
	spq_rsp_if rsp ();

	sorted_priority_queue_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source)
	);

	always #1 clk = ~clk;

	// Shadow copy of the queue contents in service order.
	logic [PRIO_W-1:0]   shadow_prio [QUEUE_DEPTH];
	logic [HANDLE_W-1:0] shadow_handle [QUEUE_DEPTH];
	int                  shadow_fill = 0;

	rsp_t pending_results [$];
	int   error_count = 0;
	bit   idle_on = 1'b1;

	dir_row_t directed_rows [NUM_ROWS] = '{
		// Dequeue right after reset finds the queue empty.
		'{ACT_REMOVE, 16'h0000, 16'h0000, 1, 1'b1, '{1'b0, 16'h0, 16'h0, 1'b1, 7'd0, ST_EMPTY}},
		'{ACT_INSERT, 16'h1000, 16'h0001, 1, 1'b1, '{1'b0, 16'h0, 16'h0, 1'b0, 7'd1, ST_OK}},
		'{ACT_INSERT, 16'hFFFF, 16'hFFFF, 1, 1'b1, '{1'b0, 16'h0, 16'h0, 1'b0, 7'd2, ST_OK}},
		// Strictly below the head, so it becomes the new head.
		'{ACT_INSERT, 16'h0000, 16'h0000, 1, 1'b1, '{1'b0, 16'h0, 16'h0, 1'b0, 7'd3, ST_OK}},
		// A tie with the head lands behind it.
		'{ACT_INSERT, 16'h0000, 16'h0002, 1, 1'b0, '0},
		// A tie with a later entry lands in front of it, at the tail too.
		'{ACT_INSERT, 16'h1000, 16'h0003, 1, 1'b0, '0},
		'{ACT_INSERT, 16'hFFFF, 16'h0004, 1, 1'b0, '0},
		'{ACT_INSERT, 16'h8000, 16'hAAAA, 1, 1'b0, '0},
		'{ACT_INSERT, 16'h5555, 16'h5555, 1, 1'b0, '0},
		'{ACT_REMOVE, 16'hFFFF, 16'hFFFF, 8, 1'b0, '0},
		'{ACT_REMOVE, 16'h0000, 16'h0000, 1, 1'b1, '{1'b0, 16'h0, 16'h0, 1'b1, 7'd0, ST_EMPTY}},
		'{ACT_INSERT, 16'h7FFF, 16'h1234, 1, 1'b1, '{1'b0, 16'h0, 16'h0, 1'b0, 7'd1, ST_OK}},
		'{ACT_REMOVE, 16'h0000, 16'h0000, 1, 1'b1,
			'{1'b1, 16'h1234, 16'h7FFF, 1'b1, 7'd0, ST_OK}},
		// Fill the queue to the brim, then insert twice more into the full queue.
		'{ACT_INSERT, 16'h0000, 16'h0000, QUEUE_DEPTH, 1'b0, '0},
		'{ACT_INSERT, 16'h0000, 16'h0000, 1, 1'b1, '{1'b0, 16'h0, 16'h0, 1'b0, 7'd64, ST_FULL}},
		'{ACT_INSERT, 16'hFFFF, 16'hFFFF, 1, 1'b1, '{1'b0, 16'h0, 16'h0, 1'b0, 7'd64, ST_FULL}}
	};

	// Applies one item to the shadow queue and returns the result it should give.
	function automatic rsp_t apply_queue_op(req_t item);
		rsp_t res;
		int   pos;
		int   i;
		res = '0;
		res.status = ST_OK;
		if (item.action == ACT_INSERT) begin
			if (shadow_fill >= QUEUE_DEPTH) begin
				res.status = ST_FULL;
			end else begin
				// Below the head takes the head; otherwise go ahead of the first
				// later entry whose priority is not lower.
				if (shadow_fill == 0 || item.item_priority < shadow_prio[0]) begin
					pos = 0;
				end else begin
					pos = 1;
					while (pos < shadow_fill && shadow_prio[pos] < item.item_priority)
						pos++;
				end
				for (i = shadow_fill; i > pos; i--) begin
					shadow_prio[i]   = shadow_prio[i-1];
					shadow_handle[i] = shadow_handle[i-1];
				end
				shadow_prio[pos]   = item.item_priority;
				shadow_handle[pos] = item.item_handle;
				shadow_fill++;
			end
		end else if (shadow_fill == 0) begin
			res.status = ST_EMPTY;
		end else begin
			res.out_valid    = 1'b1;
			res.out_handle   = shadow_handle[0];
			res.out_priority = shadow_prio[0];
			for (i = 1; i < shadow_fill; i++) begin
				shadow_prio[i-1]   = shadow_prio[i];
				shadow_handle[i-1] = shadow_handle[i];
			end
			shadow_fill--;
		end
		res.queue_empty = (shadow_fill == 0);
		res.fill_count  = shadow_fill[CNT_W-1:0];
		return res;
	endfunction

	// Priorities lean toward a narrow band and the extremes so that ties are common.
	function automatic logic [PRIO_W-1:0] random_priority();
		case ($urandom_range(3))
			0: return PRIO_W'($urandom_range(7));
			1: return $urandom_range(1) ? {PRIO_W{1'b1}} : '0;
			default: return PRIO_W'($urandom);
		endcase
	endfunction

	function automatic void check_field(string name, logic [31:0] exp, logic [31:0] got);
		if (got !== exp) begin
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp, got);
			error_count++;
		end
	endfunction

	// Offers one item, waits for it to be taken and records its expected result.
	task automatic send_item(req_t item, bit typed, rsp_t typed_rsp);
		rsp_t predicted;
		if (idle_on && $urandom_range(3) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.data  <= item;
		do @(negedge clk); while (!req.ready);
		// The item is taken at the coming rising edge.
		predicted = apply_queue_op(item);
		pending_results.push_back(typed ? typed_rsp : predicted);
		@(posedge clk);
	endtask

	// Result sink: ready drops in random bursts while idling is on.
	initial begin
		int stall_left;
		stall_left = 0;
		rsp.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				stall_left--;
				rsp.ready <= 1'b0;
			end else if (idle_on && $urandom_range(4) == 0) begin
				stall_left = $urandom_range(0, 2);
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	// Each result taken is compared with the oldest expectation.
	always @(negedge clk) begin
		rsp_t exp;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual %0h", $time, rsp.data);
				error_count++;
			end else begin
				exp = pending_results.pop_front();
				check_field("out_valid", exp.out_valid, rsp.data.out_valid);
				check_field("out_handle", exp.out_handle, rsp.data.out_handle);
				check_field("out_priority", exp.out_priority, rsp.data.out_priority);
				check_field("queue_empty", exp.queue_empty, rsp.data.queue_empty);
				check_field("fill_count", exp.fill_count, rsp.data.fill_count);
				check_field("status", exp.status, rsp.data.status);
			end
		end
	end

	// Watchdog: ends the run when nothing moves on either channel for too long.
	initial begin
		int stalled;
		stalled = 0;
		while (stalled < STALL_LIMIT) begin
			@(negedge clk);
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
				stalled = 0;
			else
				stalled++;
		end
		$display("*** FAILED ***");
		$finish;
	end

	// Stimulus: the directed table, then random segments, then the drain.
	initial begin
		req_t item;
		int   r;
		int   n;
		int   k;
		int   ins_pct;
		arst_n    = 1'b0;
		req.valid = 1'b0;
		req.data  = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		for (r = 0; r < NUM_ROWS; r++) begin
			for (n = 0; n < directed_rows[r].reps; n++) begin
				item.action        = directed_rows[r].act;
				item.item_priority = directed_rows[r].prio;
				item.item_handle   = directed_rows[r].handle;
				if (directed_rows[r].reps > 1) begin
					item.item_priority = random_priority();
					item.item_handle   = HANDLE_W'($urandom);
				end
				send_item(item, directed_rows[r].typed, directed_rows[r].exp);
			end
		end

		// Each segment picks at random between filling, draining and a balanced mix.
		ins_pct = 50;
		for (k = 0; k < RANDOM_ITEMS; k++) begin
			if (k % SEGMENT == 0) begin
				case ($urandom_range(2))
					0: ins_pct = 85;
					1: ins_pct = 15;
					default: ins_pct = 50;
				endcase
				idle_on = (k < RANDOM_ITEMS - QUIET_TAIL) && ($urandom_range(3) != 0);
			end
			item.action        = ($urandom_range(99) < ins_pct) ? ACT_INSERT : ACT_REMOVE;
			item.item_priority = random_priority();
			item.item_handle   = HANDLE_W'($urandom);
			send_item(item, 1'b0, '0);
		end

		req.valid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (4) @(posedge clk);
		if (error_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
